// ===== rtl/tmf_pkg.sv =====
package tmf_pkg;

  // Data formats
  localparam int DW           = 32;   // Q16.16 field width
  localparam int ZW           = 34;   // CORDIC angle width, Q2.30
  localparam int AW           = 50;   // x/y width of the arctangent chains
  localparam int SW           = 34;   // x/y width of the sine chain
  localparam int NUM_REGS     = 7;
  localparam int IDX_W        = 3;
  localparam int ATAN_LEN     = 24;
  localparam int CORDIC_STEPS_DEF = 16;

  // Register indexes
  localparam logic [IDX_W-1:0] REG_LAT_STIFF = 3'd0;
  localparam logic [IDX_W-1:0] REG_LAT_SHAPE = 3'd1;
  localparam logic [IDX_W-1:0] REG_LAT_CURV  = 3'd2;
  localparam logic [IDX_W-1:0] REG_LON_STIFF = 3'd3;
  localparam logic [IDX_W-1:0] REG_LON_SHAPE = 3'd4;
  localparam logic [IDX_W-1:0] REG_LON_CURV  = 3'd5;
  localparam logic [IDX_W-1:0] REG_PEAK_MU   = 3'd6;

  localparam logic signed [DW-1:0] RST_STIFF = 32'sd655360;
  localparam logic signed [DW-1:0] RST_SHAPE = 32'sd124518;
  localparam logic signed [DW-1:0] RST_CURV  = 32'sd63570;
  localparam logic signed [DW-1:0] RST_PEAK  = 32'sd65536;

  // Arithmetic constants
  localparam logic [26:0] DEG2RAD_Q32 = 27'd74961321;
  localparam logic signed [DW-1:0] INV2PI_Q32 = 32'sd683565276;
  localparam logic signed [DW-1:0] HALFPI_Q30 = 32'sd1686629713;
  localparam logic signed [SW-1:0] GAIN_Q30   = 34'sd652032874;
  localparam logic signed [AW-1:0] ONE_Q30    = 50'sd1073741824;
  localparam logic signed [ZW-1:0] HALF_LSB14 = 34'sd8192;

  localparam logic [31:0] ATAN_TAB [ATAN_LEN] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F
  };

  typedef struct packed {
    logic                   mode;
    logic signed [DW-1:0]   slip;
  } sample_t;

  typedef struct packed {
    logic signed [DW-1:0]   friction;
  } result_t;

  // Round a Q32.32 product to Q16.16, ties up, and saturate
  function automatic logic signed [DW-1:0] qround(input logic signed [63:0] p);
    logic signed [63:0] r;
    r = (p + 64'sd32768) >>> 16;
    if (r > 64'sd2147483647) return 32'sh7FFFFFFF;
    else if (r < -64'sd2147483648) return 32'sh80000000;
    else return r[DW-1:0];
  endfunction

  // Q2.30 to Q16.16, rounded
  function automatic logic signed [DW-1:0] rnd14(input logic signed [ZW-1:0] v);
    logic signed [ZW-1:0] r;
    r = (v + HALF_LSB14) >>> 14;
    return r[DW-1:0];
  endfunction

  // Saturate a 33-bit sum to 32 bits
  function automatic logic signed [DW-1:0] sat33(input logic signed [DW:0] v);
    if (v[DW] != v[DW-1]) return v[DW] ? 32'sh80000000 : 32'sh7FFFFFFF;
    else return v[DW-1:0];
  endfunction

endpackage

// ===== rtl/tmf_stream_if.sv =====
interface tmf_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/tmf_cordic_cell.sv =====
module tmf_cordic_cell #(
  parameter int STEP = 0,
  parameter int ROT  = 0,
  parameter int XW   = tmf_pkg::AW,
  parameter int SIDW = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          valid_in,
  input  logic signed [XW-1:0]          x_in,
  input  logic signed [XW-1:0]          y_in,
  input  logic signed [tmf_pkg::ZW-1:0] z_in,
  input  logic [SIDW-1:0]               side_in,
  output logic                          valid,
  output logic signed [XW-1:0]          x,
  output logic signed [XW-1:0]          y,
  output logic signed [tmf_pkg::ZW-1:0] z,
  output logic [SIDW-1:0]               side
);
  import tmf_pkg::*;

  localparam logic signed [ZW-1:0] ANGLE = ZW'(ATAN_TAB[STEP]);

  logic signed [XW-1:0] xs, ys, x_next, y_next;
  logic signed [ZW-1:0] z_next;
  logic                 go, plus;

  // Pick the rotation direction from y (vectoring) or z (rotation)
  always_comb begin
    xs   = x_in >>> STEP;
    ys   = y_in >>> STEP;
    go   = (ROT != 0) ? !z_in[ZW-1] : !y_in[XW-1];
    plus = ((ROT == 0) == go);
    if (plus) begin
      x_next = x_in + ys;
      y_next = y_in - xs;
      z_next = z_in + ANGLE;
    end else begin
      x_next = x_in - ys;
      y_next = y_in + xs;
      z_next = z_in - ANGLE;
    end
  end

  // Advance one micro-rotation
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (en) begin
      valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x    <= x_next;
      y    <= y_next;
      z    <= z_next;
      side <= side_in;
    end
  end

endmodule

// ===== rtl/tmf_cordic_chain.sv =====
module tmf_cordic_chain #(
  parameter int STEPS = tmf_pkg::CORDIC_STEPS_DEF,
  parameter int ROT   = 0,
  parameter int XW    = tmf_pkg::AW,
  parameter int SIDW  = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          valid_in,
  input  logic signed [XW-1:0]          x_in,
  input  logic signed [XW-1:0]          y_in,
  input  logic signed [tmf_pkg::ZW-1:0] z_in,
  input  logic [SIDW-1:0]               side_in,
  output logic                          valid_out,
  output logic signed [XW-1:0]          x_out,
  output logic signed [XW-1:0]          y_out,
  output logic signed [tmf_pkg::ZW-1:0] z_out,
  output logic [SIDW-1:0]               side_out
);
  import tmf_pkg::*;

  logic                 vs [0:STEPS];
  logic signed [XW-1:0] xs [0:STEPS];
  logic signed [XW-1:0] ys [0:STEPS];
  logic signed [ZW-1:0] zs [0:STEPS];
  logic [SIDW-1:0]      ss [0:STEPS];

  assign vs[0] = valid_in;
  assign xs[0] = x_in;
  assign ys[0] = y_in;
  assign zs[0] = z_in;
  assign ss[0] = side_in;

  // One cell per iteration, each handing to the next
  for (genvar k = 0; k < STEPS; k++) begin : g_cell
    tmf_cordic_cell #(
      .STEP(k), .ROT(ROT), .XW(XW), .SIDW(SIDW)
    ) u_cell (
      .clk(clk), .rst(rst), .en(en),
      .valid_in(vs[k]), .x_in(xs[k]), .y_in(ys[k]), .z_in(zs[k]), .side_in(ss[k]),
      .valid(vs[k+1]), .x(xs[k+1]), .y(ys[k+1]), .z(zs[k+1]), .side(ss[k+1])
    );
  end

  assign valid_out = vs[STEPS];
  assign x_out     = xs[STEPS];
  assign y_out     = ys[STEPS];
  assign z_out     = zs[STEPS];
  assign side_out  = ss[STEPS];

endmodule

// ===== rtl/tire_magic_formula_friction.sv =====
// Simplified magic-formula tire friction: D*sin(C*atan(Bx - E*(Bx - atan(Bx)))) on signed
// Q16.16 data, with x the absolute slip ratio or the absolute slip angle turned to radians.
// The block is a pipeline that takes one item every cycle unless the output stalls, and
// returns exactly one result per item, in order. The three CORDIC evaluations (two
// arctangents and one sine) are rows of CORDIC_STEPS cells, one micro-rotation per cell.
// When a result waits at the output the whole pipeline holds, and ready drops only while
// the output is full and not taken. Write the coefficient registers only while no item is
// in flight.
module tire_magic_formula_friction #(
  parameter int CORDIC_STEPS = tmf_pkg::CORDIC_STEPS_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  tmf_stream_if.sink                    sample,
  tmf_stream_if.source                  result,
  input  logic                          cfg_we,
  input  logic [tmf_pkg::IDX_W-1:0]     cfg_index,
  input  logic [tmf_pkg::DW-1:0]        cfg_data
);
  import tmf_pkg::*;

  logic signed [DW-1:0] lat_stiffness, lat_shape, lat_curvature;
  logic signed [DW-1:0] lon_stiffness, lon_shape, lon_curvature, peak_mu;

  logic adv;
  sample_t smp;

  // Stage registers
  logic                 v1, v2, v3, v4, v5, v6, v7, v8, v9, v10, v11, v12, v13, v14, v15;
  logic                 mode1, mode2;
  logic [DW-2:0]        a1, a2;
  logic signed [DW-1:0] b1, c1, e1, b2, c2, e2, b3, c3, e3, c4, e4, c5, e5;
  logic [57:0]          degp2;
  logic signed [DW-1:0] x3;
  logic signed [63:0]   p4, p7, p9, p11, p13, p15;
  logic signed [DW-1:0] bx5, d6, c6, e6, bx6, c7, bx7, inner8, c8, ang10, d14;
  logic signed [DW:0]   s12;
  logic signed [ZW-1:0] z14;
  logic                 out_valid;
  logic signed [DW-1:0] out_friction;

  // Chain outputs
  logic                 cv1, cv2, cv3;
  logic signed [AW-1:0] cx1, cy1, cx2, cy2;
  logic signed [SW-1:0] cx3, cy3;
  logic signed [ZW-1:0] cz1, cz2, cz3;
  logic [3*DW-1:0]      cs1;
  logic [DW-1:0]        cs2, cs3;

  logic [DW-1:0]        phase11;
  logic signed [DW:0]   ph33;
  logic signed [63:0]   z_rnd;
  logic [DW-2:0]        abs_slip;
  logic signed [DW-1:0] neg_slip;
  logic [57:0]          deg_rnd;
  logic signed [DW-1:0] atan_bx, e_term;

  assign smp          = sample.data;
  assign adv          = !out_valid || result.ready;
  assign sample.ready = adv;
  assign result.valid = out_valid;
  assign result.data.friction = out_friction;

  // Register writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      lat_stiffness <= RST_STIFF;
      lat_shape     <= RST_SHAPE;
      lat_curvature <= RST_CURV;
      lon_stiffness <= RST_STIFF;
      lon_shape     <= RST_SHAPE;
      lon_curvature <= RST_CURV;
      peak_mu       <= RST_PEAK;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LAT_STIFF: lat_stiffness <= cfg_data;
        REG_LAT_SHAPE: lat_shape     <= cfg_data;
        REG_LAT_CURV:  lat_curvature <= cfg_data;
        REG_LON_STIFF: lon_stiffness <= cfg_data;
        REG_LON_SHAPE: lon_shape     <= cfg_data;
        REG_LON_CURV:  lon_curvature <= cfg_data;
        REG_PEAK_MU:   peak_mu       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Valid bits of the plain stages
  always_ff @(posedge clk) begin
    if (rst) begin
      {v1, v2, v3, v4, v5, v6, v7, v8} <= '0;
      {v9, v10, v11, v12, v13, v14, v15} <= '0;
      out_valid <= 1'b0;
    end else if (adv) begin
      v1 <= sample.valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= cv1;
      v7 <= v6;
      v8 <= v7;
      v9 <= cv2;
      v10 <= v9;
      v11 <= v10;
      v12 <= v11;
      v13 <= v12;
      v14 <= v13;
      v15 <= cv3;
      out_valid <= v15;
    end
  end

  // Absolute slip; the most negative value saturates
  assign neg_slip = -smp.slip;

  always_comb begin
    if (!smp.slip[DW-1]) abs_slip = smp.slip[DW-2:0];
    else if (smp.slip == 32'sh80000000) abs_slip = '1;
    else abs_slip = neg_slip[DW-2:0];
  end

  assign deg_rnd = degp2 + 58'h80000000;
  assign phase11 = DW'((p11 + 64'sd32768) >>> 16);
  assign ph33    = {phase11[DW-1], phase11};
  assign z_rnd   = (p13 + 64'sd536870912) >>> 30;
  assign atan_bx = rnd14(cz1);
  assign e_term  = qround(p7);

  // Front end: abs, unit conversion, B*x
  always_ff @(posedge clk) begin
    if (adv) begin
      mode1 <= smp.mode;
      a1    <= abs_slip;
      b1    <= smp.mode ? lon_stiffness : lat_stiffness;
      c1    <= smp.mode ? lon_shape     : lat_shape;
      e1    <= smp.mode ? lon_curvature : lat_curvature;

      mode2 <= mode1;
      a2    <= a1;
      degp2 <= 58'(a1) * 58'(DEG2RAD_Q32);
      {b2, c2, e2} <= {b1, c1, e1};

      x3 <= mode2 ? {1'b0, a2} : {6'd0, deg_rnd[57:32]};
      {b3, c3, e3} <= {b2, c2, e2};

      p4 <= b3 * x3;
      {c4, e4} <= {c3, e3};

      bx5 <= qround(p4);
      {c5, e5} <= {c4, e4};
    end
  end

  // atan(Bx)
  tmf_cordic_chain #(.STEPS(CORDIC_STEPS), .ROT(0), .XW(AW), .SIDW(3*DW)) u_atan1 (
    .clk(clk), .rst(rst), .en(adv),
    .valid_in(v5), .x_in(ONE_Q30), .y_in({{4{bx5[DW-1]}}, bx5, 14'd0}), .z_in('0),
    .side_in({c5, e5, bx5}),
    .valid_out(cv1), .x_out(cx1), .y_out(cy1), .z_out(cz1), .side_out(cs1)
  );

  // Inner argument: Bx - E*(Bx - atan(Bx))
  always_ff @(posedge clk) begin
    if (adv) begin
      d6  <= sat33({cs1[DW-1], cs1[DW-1:0]} - {atan_bx[DW-1], atan_bx});
      c6  <= cs1[3*DW-1:2*DW];
      e6  <= cs1[2*DW-1:DW];
      bx6 <= cs1[DW-1:0];

      p7  <= e6 * d6;
      c7  <= c6;
      bx7 <= bx6;

      inner8 <= sat33({bx7[DW-1], bx7} - {e_term[DW-1], e_term});
      c8     <= c7;
    end
  end

  // atan(inner)
  tmf_cordic_chain #(.STEPS(CORDIC_STEPS), .ROT(0), .XW(AW), .SIDW(DW)) u_atan2 (
    .clk(clk), .rst(rst), .en(adv),
    .valid_in(v8), .x_in(ONE_Q30), .y_in({{4{inner8[DW-1]}}, inner8, 14'd0}), .z_in('0),
    .side_in(c8),
    .valid_out(cv2), .x_out(cx2), .y_out(cy2), .z_out(cz2), .side_out(cs2)
  );

  // Angle, phase in turns, fold to the right half plane, scale to radians
  always_ff @(posedge clk) begin
    if (adv) begin
      p9    <= $signed(cs2) * rnd14(cz2);
      ang10 <= qround(p9);
      p11   <= ang10 * INV2PI_Q32;
      if (ph33 > 33'sd1073741824) s12 <= 33'sd2147483648 - ph33;
      else if (ph33 < -33'sd1073741824) s12 <= -33'sd2147483648 - ph33;
      else s12 <= ph33;
      p13   <= 64'(s12) * 64'(HALFPI_Q30);
      z14   <= z_rnd[ZW-1:0];
      d14   <= peak_mu;
    end
  end

  // sin(angle)
  tmf_cordic_chain #(.STEPS(CORDIC_STEPS), .ROT(1), .XW(SW), .SIDW(DW)) u_sin (
    .clk(clk), .rst(rst), .en(adv),
    .valid_in(v14), .x_in(GAIN_Q30), .y_in('0), .z_in(z14),
    .side_in(d14),
    .valid_out(cv3), .x_out(cx3), .y_out(cy3), .z_out(cz3), .side_out(cs3)
  );

  // D*sin and the output register
  always_ff @(posedge clk) begin
    if (adv) begin
      p15          <= $signed(cs3) * rnd14(cy3);
      out_friction <= qround(p15);
    end
  end

endmodule

// ===== rtl/tmf_checker.sv =====
module tmf_props (
  input logic                 clk,
  input logic                 rst,
  input logic                 sample_ready,
  input logic                 result_valid,
  input logic                 result_ready,
  input logic signed [31:0]   friction
);

  // Output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

  // Input is held back exactly while a result sits untaken
  a_ready_link: assert property (@(posedge clk) disable iff (rst)
    sample_ready == (!result_valid || result_ready))
    else $error("input ready does not follow output stall");

  // A stalled result holds its value
  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> result_valid && $stable(friction))
    else $error("stalled result changed");

  // A stalled output keeps the input closed in the next cycle too, unless the result is taken then
  a_stall_input: assert property (@(posedge clk) disable iff (rst)
    result_valid && !result_ready |=> !sample_ready || result_ready)
    else $error("input opened while output stalled");

endmodule

bind tire_magic_formula_friction tmf_props u_chk (
  .clk(clk),
  .rst(rst),
  .sample_ready(sample.ready),
  .result_valid(result.valid),
  .result_ready(result.ready),
  .friction(result.data.friction)
);
